[rtl/esc_pkg.sv]
// Types, constants and month table shared by the epoch-to-calendar block.
`default_nettype none
package esc_pkg;

  localparam int CNT_W      = 32;
  localparam int REM_W      = 6;
  localparam int DAY_W      = 16;
  localparam int YEAR_W     = 12;
  localparam int YEAR_INT_W = YEAR_W + 1;
  localparam int OUT_W      = 40;

  localparam logic [REM_W-1:0] SECS_PER_MIN  = 6'd60;
  localparam logic [REM_W-1:0] MINS_PER_HOUR = 6'd60;
  localparam logic [REM_W-1:0] HOURS_PER_DAY = 6'd24;

  // floor(n / 60) = (n * RECIP_60) >> SHIFT_60, floor(n / 24) likewise, for any 32-bit n
  localparam logic [CNT_W-1:0] RECIP_60 = 32'h8888_8889;
  localparam int               SHIFT_60 = 37;
  localparam logic [CNT_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int               SHIFT_24 = 36;

  localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

  localparam logic [YEAR_W-1:0] EPOCH_RESET = 12'd1970;
  localparam logic [YEAR_W-1:0] YEARS_400   = 12'd400;
  localparam logic [YEAR_W-1:0] CENT_1      = 12'd100;
  localparam logic [YEAR_W-1:0] CENT_2      = 12'd200;
  localparam logic [YEAR_W-1:0] CENT_3      = 12'd300;
  localparam logic [YEAR_W-1:0] CYCLE_LAST  = 12'd399;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef enum logic [1:0] {
    DIV_SEC  = 2'd0,
    DIV_MIN  = 2'd1,
    DIV_HOUR = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_step;
    logic     div_done;
    div_sel_t div_sel;
    logic     m400_step;
    logic     year_step;
    logic     month_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic m400_ge;
    logic year_done;
    logic month_done;
    logic out_free;
  } sts_t;

  // common-year month lengths, January is index 0
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/esc_ctrl.sv]
// Sequencer for the epoch-to-calendar datapath: divide, mod-400 reduction, year walk, month walk, hand-off.
`default_nettype none
module esc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output esc_pkg::cmd_t      cmd,
  input  wire esc_pkg::sts_t sts
);
  import esc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_M400  = 6'b000100,
    ST_YEAR  = 6'b001000,
    ST_MONTH = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       rem_phase_r, rem_phase_nxt;
  div_sel_t   sel_r, sel_nxt;

  always_comb begin
    state_nxt     = state_r;
    rem_phase_nxt = rem_phase_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in   = 1'b1;
          rem_phase_nxt = 1'b0;
          sel_nxt       = DIV_SEC;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!rem_phase_r) begin
          cmd.div_step  = 1'b1;
          rem_phase_nxt = 1'b1;
        end else begin
          cmd.div_done  = 1'b1;
          rem_phase_nxt = 1'b0;
          case (sel_r)
            DIV_SEC:  sel_nxt = DIV_MIN;
            DIV_MIN:  sel_nxt = DIV_HOUR;
            default:  state_nxt = ST_M400;
          endcase
        end
      end
      ST_M400: begin
        if (sts.m400_ge) begin
          cmd.m400_step = 1'b1;
        end else begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_phase_r <= 1'b0;
      sel_r       <= DIV_SEC;
    end else begin
      state_r     <= state_nxt;
      rem_phase_r <= rem_phase_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a beat is in progress");
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");
  a_rem_after_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> cmd.div_done)
    else $error("remainder not taken after quotient");
`endif

endmodule
`default_nettype wire

[rtl/esc_dp.sv]
// Datapath: reciprocal-multiply constant divider, leap tracking, year and month walk, result reg.
`default_nettype none
module esc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [esc_pkg::YEAR_W-1:0]   epoch_year,
  input  wire logic [esc_pkg::CNT_W-1:0]    in_tdata,
  input  wire esc_pkg::cmd_t                cmd,
  output esc_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [esc_pkg::OUT_W-1:0]         out_tdata
);
  import esc_pkg::*;

  logic [CNT_W-1:0]      n_r;
  logic [CNT_W-1:0]      q_r;
  logic [5:0]            sec_r, min_r;
  logic [4:0]            hour_r;
  logic [YEAR_INT_W-1:0] year_r;
  logic [YEAR_W-1:0]     m400_r;
  logic [3:0]            month_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic [REM_W-1:0]   divisor;
  logic [CNT_W-1:0]   recip;
  logic [2*CNT_W-1:0] prod;
  logic [CNT_W-1:0]   q_calc;
  logic [REM_W-1:0]   rem_step;
  logic               leap, cent;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic [4:0]         day;

  always_comb begin
    case (cmd.div_sel)
      DIV_SEC: begin
        divisor = SECS_PER_MIN;
        recip   = RECIP_60;
      end
      DIV_MIN: begin
        divisor = MINS_PER_HOUR;
        recip   = RECIP_60;
      end
      DIV_HOUR: begin
        divisor = HOURS_PER_DAY;
        recip   = RECIP_24;
      end
      default: begin
        divisor = SECS_PER_MIN;
        recip   = RECIP_60;
      end
    endcase
  end

  // quotient registered first, remainder from the registered quotient in the next cycle
  assign prod     = 64'(n_r) * 64'(recip);
  assign q_calc   = (cmd.div_sel == DIV_HOUR) ? CNT_W'(prod >> SHIFT_24)
                                              : CNT_W'(prod >> SHIFT_60);
  assign rem_step = REM_W'(n_r - q_r * CNT_W'(divisor));

  assign cent = m400_r inside {CENT_1, CENT_2, CENT_3};
  assign leap = (m400_r == '0) || ((year_r[1:0] == 2'd0) && !cent);
  assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign mlen = month_len(month_r) + {4'd0, (month_r == MONTH_FEB) && leap};
  assign day  = n_r[4:0] + 5'd1;

  assign sts.m400_ge    = (m400_r >= YEARS_400);
  assign sts.year_done  = (n_r[DAY_W-1:0] < {7'd0, ylen});
  assign sts.month_done = (n_r[DAY_W-1:0] < {11'd0, mlen}) || (month_r == MONTH_DEC);
  assign sts.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      n_r     <= in_tdata;
      year_r  <= {1'b0, epoch_year};
      m400_r  <= epoch_year;
      month_r <= MONTH_JAN;
    end
    if (cmd.div_step) begin
      q_r <= q_calc;
    end
    if (cmd.div_done) begin
      n_r <= q_r;
      case (cmd.div_sel)
        DIV_SEC:  sec_r  <= rem_step;
        DIV_MIN:  min_r  <= rem_step;
        default:  hour_r <= rem_step[4:0];
      endcase
    end
    if (cmd.m400_step) begin
      m400_r <= m400_r - YEARS_400;
    end
    if (cmd.year_step) begin
      n_r    <= n_r - {23'd0, ylen};
      year_r <= year_r + 13'd1;
      m400_r <= (m400_r == CYCLE_LAST) ? '0 : m400_r + 12'd1;
    end
    if (cmd.month_step) begin
      n_r     <= n_r - {27'd0, mlen};
      month_r <= month_r + 4'd1;
    end
    if (cmd.load_out) begin
      out_data_r <= {2'b00, year_r[YEAR_W-1:0], month_r + 4'd1, day, hour_r, min_r, sec_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_day_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |-> (n_r[CNT_W-1:DAY_W] == '0))
    else $error("day count wider than expected in year walk");
  a_cycle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |-> (m400_r < YEARS_400))
    else $error("400-year position out of range");
  a_month_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.month_step |-> (month_r != MONTH_DEC))
    else $error("month walk past December");
`endif

endmodule
`default_nettype wire

[rtl/epoch_seconds_to_calendar.sv]
// Top level: epoch seconds to Gregorian date and time, with base-year register.
//
// Input beat: in_tdata carries a 32-bit unsigned seconds count since midnight,
// January 1 of the base year. Output beat: one date/time per input beat.
// Base year is written through cfg_valid/cfg_data (always ready, resets to 1970);
// write it only while the block is idle.
// Processing: after the accept, division by 60, 60 and 24 (reciprocal multiply,
// then remainder), reduction of the base year mod 400, one step per elapsed
// year, one step per elapsed month, and a load of the result register, after
// which out_tvalid rises.
// One item is in work at a time; in_tready is high only when idle, so a new beat
// is not taken until the previous one has been loaded into the result register.
// The result register frees the core: a new beat can be taken while the
// previous result still waits on a stalled out_tready. If that result is still
// waiting when the next one is ready, the core holds and in_tready stays low.
// Reset (rst_n low, synchronous) drops out_tvalid and returns to idle.
`default_nettype none
module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seconds_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [5:0] sec_of_min, [11:6] min_of_hour,
                                       // [16:12] hour_of_day, [21:17] day_of_month,
                                       // [25:22] month_num, [37:26] year_num, [39:38] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data    // epoch_year
);
  import esc_pkg::*;

  logic [YEAR_W-1:0] epoch_r;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      epoch_r <= cfg_data;
    end
  end

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  esc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .epoch_year (epoch_r),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
